[rtl/paper_tape_bin_loader_macros.svh]
// Assertion macros for the paper tape BIN loader.
// Every macro expects clk and arst_n in the scope where it is used.
`ifndef PAPER_TAPE_BIN_LOADER_MACROS_SVH
`define PAPER_TAPE_BIN_LOADER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTBL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTBL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[rtl/ptbl_pkg.sv]
// Shared types and constants of the paper tape BIN loader.
// No dependencies.
`default_nettype none

package ptbl_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_OK    = 2'd1,
		KIND_BAD   = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	localparam logic [7:0] LEADER_BYTE  = 8'h00;
	localparam logic [7:0] TRAILER_BYTE = 8'h80;

	// Frame types from the two top bits of a byte.
	localparam logic [1:0] TOP_DATA   = 2'b00;
	localparam logic [1:0] TOP_ORIGIN = 2'b01;
	localparam logic [1:0] TOP_BAD    = 2'b10;
	localparam logic [1:0] TOP_FIELD  = 2'b11;

endpackage

`default_nettype wire

[rtl/paper_tape_bin_loader.sv]
// Paper tape BIN loader: byte-stream parser producing memory writes and an end status.
// Depends on ptbl_pkg and paper_tape_bin_loader_macros.svh.
//
// The loader takes one tape byte per transfer and gives at most one result per byte.
// A byte is captured in an input register and parsed in the next cycle against the
// loader state, and any result lands in an output register; a byte can be taken in
// every cycle. The only stall comes from the output register: a byte that produces a
// result waits in the input register while the previous result has not been taken.
// A result passes from the input register through the output register before it is offered. After
// the trailer or a format error all further bytes are consumed without results until reset.
`default_nettype none

module paper_tape_bin_loader
	import ptbl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  tape_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [14:0]      write_address,
	output logic [11:0]      write_word,
	output logic [11:0]      computed_sum,
	output logic [11:0]      tape_sum
);

	typedef enum logic [1:0] {
		PH_LEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	// Input stage
	logic       valid_s1;
	logic [7:0] tape_byte_s1;

	// Loader state
	phase_t      phase_q;
	logic        half_pair_q;
	logic [7:0]  first_byte_q;
	logic        pend_valid_q;
	logic        pend_data_q;
	logic [11:0] pend_word_q;
	logic [8:0]  pend_sum_q;
	logic [11:0] run_sum_q;
	logic [2:0]  field_q;
	logic [11:0] addr_q;

	// Next state and result
	phase_t      phase_d;
	logic        half_pair_d;
	logic [7:0]  first_byte_d;
	logic        pend_valid_d;
	logic        pend_data_d;
	logic [11:0] pend_word_d;
	logic [8:0]  pend_sum_d;
	logic [11:0] run_sum_d;
	logic [2:0]  field_d;
	logic [11:0] addr_d;

	logic        res_valid;
	kind_t       res_kind;
	logic [14:0] res_addr;
	logic [11:0] res_word;
	logic [11:0] res_csum;
	logic [11:0] res_tsum;
	logic [11:0] tsum_sel;

	logic out_free;
	logic s1_go;

	assign out_free = !out_valid || out_ready;
	assign s1_go    = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || s1_go;

	always_comb begin
		logic [7:0] c;
		logic       body;
		c            = tape_byte_s1;
		phase_d      = phase_q;
		half_pair_d  = half_pair_q;
		first_byte_d = first_byte_q;
		pend_valid_d = pend_valid_q;
		pend_data_d  = pend_data_q;
		pend_word_d  = pend_word_q;
		pend_sum_d   = pend_sum_q;
		run_sum_d    = run_sum_q;
		field_d      = field_q;
		addr_d       = addr_q;
		res_valid    = 1'b0;
		res_kind     = KIND_WRITE;
		res_addr     = '0;
		res_word     = '0;
		res_csum     = '0;
		res_tsum     = '0;
		tsum_sel     = pend_valid_q ? pend_word_q : 12'd0;
		body         = 1'b0;

		case (phase_q)
			PH_LEADER: begin
				if (c != LEADER_BYTE && c != TRAILER_BYTE) begin
					phase_d = PH_BODY;
					body    = 1'b1;
				end
			end
			PH_BODY: body = 1'b1;
			default: body = 1'b0;
		endcase

		if (body) begin
			if (half_pair_q) begin
				pend_word_d  = {first_byte_q[5:0], c[5:0]};
				pend_sum_d   = {1'b0, first_byte_q} + {1'b0, c};
				pend_data_d  = (first_byte_q[7:6] == TOP_DATA);
				pend_valid_d = 1'b1;
				half_pair_d  = 1'b0;
			end else if (c == TRAILER_BYTE) begin
				// The pending pair turns out to be the tape checksum.
				res_valid    = 1'b1;
				res_kind     = (run_sum_q == tsum_sel) ? KIND_OK : KIND_BAD;
				res_csum     = run_sum_q;
				res_tsum     = tsum_sel;
				pend_valid_d = 1'b0;
				phase_d      = PH_DONE;
			end else if (c[7:6] == TOP_BAD) begin
				res_valid    = 1'b1;
				res_kind     = KIND_ERR;
				res_csum     = run_sum_q;
				pend_valid_d = 1'b0;
				phase_d      = PH_DONE;
			end else begin
				// A new frame starts, so the pending pair is committed with the old field.
				if (pend_valid_q) begin
					run_sum_d = run_sum_q + {3'b000, pend_sum_q};
					if (pend_data_q) begin
						res_valid = 1'b1;
						res_kind  = KIND_WRITE;
						res_addr  = {field_q, addr_q};
						res_word  = pend_word_q;
						addr_d    = addr_q + 12'd1;
					end else begin
						addr_d = pend_word_q;
					end
					pend_valid_d = 1'b0;
				end
				if (c[7:6] == TOP_FIELD) begin
					field_d = c[5:3];
				end else begin
					first_byte_d = c;
					half_pair_d  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tape_byte_s1 <= tape_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEADER;
			half_pair_q  <= 1'b0;
			first_byte_q <= '0;
			pend_valid_q <= 1'b0;
			pend_data_q  <= 1'b0;
			pend_word_q  <= '0;
			pend_sum_q   <= '0;
			run_sum_q    <= '0;
			field_q      <= '0;
			addr_q       <= '0;
		end else if (s1_go) begin
			phase_q      <= phase_d;
			half_pair_q  <= half_pair_d;
			first_byte_q <= first_byte_d;
			pend_valid_q <= pend_valid_d;
			pend_data_q  <= pend_data_d;
			pend_word_q  <= pend_word_d;
			pend_sum_q   <= pend_sum_d;
			run_sum_q    <= run_sum_d;
			field_q      <= field_d;
			addr_q       <= addr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_go && res_valid) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			result_kind   <= res_kind;
			write_address <= res_addr;
			write_word    <= res_word;
			computed_sum  <= res_csum;
			tape_sum      <= res_tsum;
		end
	end

	`include "paper_tape_bin_loader_macros.svh"

	// Once the stream has ended, no byte may produce a result.
	`PTBL_ASSERT_NOW(a_done_silent, valid_s1 && phase_q == PH_DONE, !res_valid)
	// Memory writes carry no sums.
	`PTBL_ASSERT_NOW(a_write_clean, out_valid && result_kind == KIND_WRITE,
		computed_sum == 12'd0 && tape_sum == 12'd0)
	// A byte held back by a full output register keeps its value.
	`PTBL_ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_go,
		valid_s1 && $stable(tape_byte_s1))
	// An end or error result is always accompanied by the final phase.
	`PTBL_ASSERT_NOW(a_end_done, out_valid && result_kind != KIND_WRITE,
		phase_q == PH_DONE)

endmodule

`default_nettype wire

[bench/paper_tape_bin_loader_test.sv]
// Self-checking testbench for the paper tape BIN loader: one tape per run, checked per result.
// Depends on ptbl_pkg and paper_tape_bin_loader; a local model predicts writes and the end status.
`default_nettype none

module paper_tape_bin_loader_test;
	import ptbl_pkg::*;

	typedef enum logic [1:0] {
		PH_LEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2
	} load_phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [14:0] addr;
		logic [11:0] word;
		logic [11:0] csum;
		logic [11:0] tsum;
	} tape_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  tape_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [14:0] write_address;
	logic [11:0] write_word;
	logic [11:0] computed_sum;
	logic [11:0] tape_sum;

	// Loader state as the model sees it.
	load_phase_t ld_phase;
	logic        ld_half;
	logic [7:0]  ld_first;
	logic        pend_valid;
	logic        pend_data;
	logic [11:0] pend_word;
	logic [8:0]  pend_sum;
	logic [11:0] ld_sum;
	logic [2:0]  ld_field;
	logic [11:0] ld_addr;

	tape_result_t pending_results[$];

	int    errors = 0;
	int    bytes_sent = 0;
	int    results_checked = 0;
	int    writes_checked = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	string end_case = "none";

	paper_tape_bin_loader uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.tape_byte     (tape_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.write_address (write_address),
		.write_word    (write_word),
		.computed_sum  (computed_sum),
		.tape_sum      (tape_sum)
	);

	always #6 clk = ~clk;

	// Apply one accepted byte to the model and queue any result it causes.
	task automatic predict_byte(input logic [7:0] b);
		tape_result_t r;
		logic [11:0]  tsum;
		r = '0;
		if (ld_phase == PH_LEADER) begin
			if (b == LEADER_BYTE || b == TRAILER_BYTE)
				return;
			ld_phase = PH_BODY;
		end
		if (ld_phase != PH_BODY)
			return;
		if (ld_half) begin
			pend_word  = {ld_first[5:0], b[5:0]};
			pend_sum   = {1'b0, ld_first} + {1'b0, b};
			pend_data  = (ld_first[7:6] == TOP_DATA);
			pend_valid = 1'b1;
			ld_half    = 1'b0;
			return;
		end
		if (b == TRAILER_BYTE) begin
			tsum   = pend_valid ? pend_word : 12'h000;
			r.kind = (ld_sum == tsum) ? KIND_OK : KIND_BAD;
			r.csum = ld_sum;
			r.tsum = tsum;
			pending_results.push_back(r);
			pend_valid = 1'b0;
			ld_phase   = PH_DONE;
			return;
		end
		if (b[7:6] == TOP_BAD) begin
			r.kind = KIND_ERR;
			r.csum = ld_sum;
			pending_results.push_back(r);
			pend_valid = 1'b0;
			ld_phase   = PH_DONE;
			return;
		end
		// Any other frame start proves the pending pair was not the checksum.
		if (pend_valid) begin
			ld_sum = ld_sum + 12'(pend_sum);
			if (pend_data) begin
				r.kind = KIND_WRITE;
				r.addr = {ld_field, ld_addr};
				r.word = pend_word;
				pending_results.push_back(r);
				ld_addr = ld_addr + 12'd1;
			end else begin
				ld_addr = pend_word;
			end
			pend_valid = 1'b0;
		end
		if (b[7:6] == TOP_FIELD) begin
			ld_field = b[5:3];
		end else begin
			ld_first = b;
			ld_half  = 1'b1;
		end
	endtask

	// Offer one byte, idling first as the current sender setting asks. Returns just
	// after the clock edge of the transfer.
	task automatic send_byte(input logic [7:0] b);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				in_valid  <= 1'b1;
				tape_byte <= b;
				break;
			end
		end
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		predict_byte(b);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid  <= 1'b0;
		tape_byte <= 8'($urandom);
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic report_field(input string name, input logic [14:0] exp_v, act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		tape_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got kind %0d addr %0h word %0h",
					$time, result_kind, write_address, write_word);
			end else begin
				exp_r = pending_results.pop_front();
				report_field("result_kind", 15'(exp_r.kind), 15'(result_kind));
				report_field("write_address", exp_r.addr, write_address);
				report_field("write_word", 15'(exp_r.word), 15'(write_word));
				report_field("computed_sum", 15'(exp_r.csum), 15'(computed_sum));
				report_field("tape_sum", 15'(exp_r.tsum), 15'(tape_sum));
				results_checked++;
				if (exp_r.kind == KIND_WRITE)
					writes_checked++;
			end
		end
	end

	task automatic test_leader_skip();
		send_byte(LEADER_BYTE);
		send_byte(TRAILER_BYTE);
		send_byte(LEADER_BYTE);
		send_byte(LEADER_BYTE);
		send_byte(TRAILER_BYTE);
	endtask

	task automatic test_frame_extremes();
		send_byte(8'hC0);               // field 0 starts the body
		send_byte(8'h7F);               // origin 0xfff
		send_byte(8'h3F);
		send_byte(8'h3F);               // data 0xfff at the top address
		send_byte(8'h3F);
		send_byte(8'h00);               // data 0, address wraps to 0
		send_byte(8'h00);
		send_byte(8'hFF);               // field 7 with junk low bits, after the old write
		send_byte(8'h2A);
		send_byte(8'hFF);               // second byte with both top bits set
		send_byte(8'h15);
		send_byte(TRAILER_BYTE);        // trailer value as a second byte
		send_byte(8'h40);
		send_byte(8'hBF);               // bad-frame pattern as a second byte
		send_byte(8'hC8);               // field 1 commits the origin
		send_byte(8'h01);
		send_byte(8'hC0);
		send_byte(8'h3F);
		send_byte(8'h7F);
	endtask

	task automatic send_random_frame(output int n);
		int         pick;
		logic [7:0] second;
		pick   = $urandom_range(99);
		second = ($urandom_range(99) < 30) ? 8'($urandom) : {TOP_DATA, 6'($urandom)};
		if (pick < 12) begin
			send_byte({TOP_FIELD, 6'($urandom)});
			n = 1;
		end else if (pick < 27) begin
			send_byte({TOP_ORIGIN, 6'($urandom)});
			send_byte(second);
			n = 2;
		end else begin
			send_byte({TOP_DATA, 6'($urandom)});
			send_byte(second);
			n = 2;
		end
	endtask

	task automatic test_random_tape(input int sidle, input int rstall, input int items);
		int sent;
		int n;
		sent           = 0;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		while (sent < items) begin
			send_random_frame(n);
			sent += n;
		end
	endtask

	task automatic test_pause_until_drained();
		release_input();
		wait_for_results();
	endtask

	task automatic test_tape_end();
		logic [11:0] s;
		logic [11:0] w;
		logic [1:0]  first_top;
		s         = pend_valid ? ld_sum + 12'(pend_sum) : ld_sum;
		first_top = $urandom_range(1) ? TOP_ORIGIN : TOP_DATA;
		case ($urandom_range(3))
			0: begin
				end_case = "matching checksum";
				send_byte({first_top, s[11:6]});
				send_byte({2'($urandom), s[5:0]});
				send_byte(TRAILER_BYTE);
			end
			1: begin
				end_case = "wrong checksum";
				w = s ^ 12'($urandom_range(1, 4095));
				send_byte({first_top, w[11:6]});
				send_byte({2'($urandom), w[5:0]});
				send_byte(TRAILER_BYTE);
			end
			2: begin
				end_case = "trailer with no pending pair";
				send_byte({TOP_FIELD, 6'($urandom)});
				send_byte(TRAILER_BYTE);
			end
			default: begin
				end_case = "format error";
				send_byte({TOP_DATA, 6'($urandom)});
				send_byte(8'($urandom));
				send_byte({TOP_BAD, 6'($urandom_range(1, 63))});
			end
		endcase
	endtask

	task automatic test_after_end();
		repeat (20)
			send_byte(8'($urandom));
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		tape_byte  = 8'h00;
		ld_phase   = PH_LEADER;
		ld_half    = 1'b0;
		ld_first   = 8'h00;
		pend_valid = 1'b0;
		pend_data  = 1'b0;
		pend_word  = 12'h000;
		pend_sum   = 9'h000;
		ld_sum     = 12'h000;
		ld_field   = 3'd0;
		ld_addr    = 12'h000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_leader_skip();
		test_frame_extremes();
		test_random_tape(0, 0, 310);
		test_random_tape(47, 0, 310);
		test_pause_until_drained();
		test_random_tape(0, 47, 310);
		test_random_tape(35, 35, 310);
		test_tape_end();
		test_after_end();

		release_input();
		wait_for_results();
		repeat (10) @(posedge clk);

		$display("Sent %0d tape bytes; checked %0d results, %0d of them memory writes.",
			bytes_sent, results_checked, writes_checked);
		$display("Tape ended with a %s; later bytes were ignored.", end_case);
		if (errors == 0)
			$display("paper_tape_bin_loader verification clean");
		else
			$display("paper_tape_bin_loader verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timed out with %0d results still expected.", pending_results.size());
		$display("paper_tape_bin_loader verification failed");
		$finish;
	end

endmodule

`default_nettype wire
